// ----- hw/rtl/cova_pkg.sv -----
// Shared widths and constants for the covariance accumulator.
`default_nettype none
package cova_pkg;

  localparam int unsigned MaxPairs = 65536;
  localparam int unsigned SampleW  = 24;
  localparam int unsigned CntW     = 17;
  localparam int unsigned SumW     = 40;
  localparam int unsigned ProdW    = 48;
  localparam int unsigned SxyW     = 64;
  localparam int unsigned WideW    = 80;
  localparam int unsigned AluW     = 66;
  localparam int unsigned CovW     = 48;
  localparam int unsigned StepW    = 7;

  localparam int unsigned MulSteps  = SumW;
  localparam int unsigned Div1Steps = WideW;
  localparam int unsigned Div2Steps = SxyW;

  localparam logic [CntW-1:0]  CntFull  = CntW'(MaxPairs);
  // the quotient saturates above this bound
  localparam logic [WideW-1:0] QLimit   = 80'h0000_4000_0000_FFFF_FFFF;
  localparam logic [SxyW-1:0]  QSatVal  = 64'h4000_0000_0000_0000;
  localparam logic [SxyW-1:0]  PosLimit = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [SxyW-1:0]  NegLimit = 64'h0000_8000_0000_0000;
  localparam logic [CovW-1:0]  CovMax   = 48'h7FFF_FFFF_FFFF;
  localparam logic [CovW-1:0]  CovMin   = 48'h8000_0000_0000;

endpackage
`default_nettype wire

// ----- hw/rtl/covariance_accumulator.sv -----
// Population covariance from running sums, on one shared 66-bit adder.
// A new transaction is taken only in idle: a non-last item passes through the
// accumulate states; a last item of an empty set goes straight to hand-over,
// else through 40 multiply and 80 + 64 divide steps on the adder, then the
// fix-up and hand-over states. A held result delays the hand-over.
// Reset (rst_ni low, asynchronous) clears the sequencer, count, sums, overflow flag and the out valid.
`default_nettype none
module covariance_accumulator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [cova_pkg::SampleW-1:0] x_value_i,
  input  logic signed [cova_pkg::SampleW-1:0] y_value_i,
  input  logic                                pair_missing_i,
  input  logic                                last_of_set_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [cova_pkg::CovW-1:0]    cov_result_o,
  output logic                                result_null_o,
  output logic                                overflow_o
);
  import cova_pkg::*;

  // sequencer codes
  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StAccX = 4'd1;   // sum_x, and register x*y
  localparam logic [3:0] StAccY = 4'd2;   // sum_y
  localparam logic [3:0] StAccP = 4'd3;   // sum_xy, count
  localparam logic [3:0] StAbsX = 4'd4;   // |sum_x|
  localparam logic [3:0] StAbsY = 4'd5;   // |sum_y|
  localparam logic [3:0] StMul  = 4'd6;   // |sx|*|sy|, one bit a cycle
  localparam logic [3:0] StDiv1 = 4'd7;   // product / n
  localparam logic [3:0] StQSat = 4'd8;   // clamp the quotient
  localparam logic [3:0] StDiff = 4'd9;   // sum_xy - q
  localparam logic [3:0] StAbsD = 4'd10;  // |difference|
  localparam logic [3:0] StDiv2 = 4'd11;  // difference / n
  localparam logic [3:0] StOut  = 4'd12;  // sign and saturate
  localparam logic [3:0] StDone = 4'd13;  // hand over, clear the set

  logic [3:0]              state_q, state_d;
  logic [StepW-1:0]        step_q;

  logic [CntW-1:0]         cnt_q;
  logic signed [SumW-1:0]  sx_q, sy_q;
  logic signed [SxyW-1:0]  sxy_q;
  logic                    ovf_q;

  logic signed [SampleW-1:0] x_q, y_q;
  logic                    last_q, take_q;
  logic signed [ProdW-1:0] prod_q;

  logic [SumW-1:0]         mag_a_q;
  logic [WideW-1:0]        p_q;      // multiply, dividend and quotient register
  logic [CntW-1:0]         rem_q;
  logic [AluW-1:0]         diff_q;
  logic                    dneg_q;
  logic [CovW-1:0]         res_q;
  logic                    null_q;

  logic                    out_valid_q;
  logic [CovW-1:0]         cov_q;
  logic                    rnull_q, rovf_q;

  // shared adder
  logic [AluW-1:0]         alu_a, alu_b, alu_sum;
  logic                    alu_sub;

  logic                    accept, qbit, hand_over, step_end;
  logic [StepW-1:0]        step_last;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign hand_over  = !out_valid_q || out_ready_i;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      StAccX: begin
        alu_a = {{(AluW-SumW){sx_q[SumW-1]}}, sx_q};
        alu_b = {{(AluW-SampleW){x_q[SampleW-1]}}, x_q};
      end
      StAccY: begin
        alu_a = {{(AluW-SumW){sy_q[SumW-1]}}, sy_q};
        alu_b = {{(AluW-SampleW){y_q[SampleW-1]}}, y_q};
      end
      StAccP: begin
        alu_a = {{(AluW-SxyW){sxy_q[SxyW-1]}}, sxy_q};
        alu_b = {{(AluW-ProdW){prod_q[ProdW-1]}}, prod_q};
      end
      StAbsX: begin
        alu_b   = {{(AluW-SumW){sx_q[SumW-1]}}, sx_q};
        alu_sub = sx_q[SumW-1];
      end
      StAbsY: begin
        alu_b   = {{(AluW-SumW){sy_q[SumW-1]}}, sy_q};
        alu_sub = sy_q[SumW-1];
      end
      StMul: begin
        alu_a = {{(AluW-(WideW-SumW)){1'b0}}, p_q[WideW-1:SumW]};
        alu_b = p_q[0] ? {{(AluW-SumW){1'b0}}, mag_a_q} : '0;
      end
      StDiv1, StDiv2: begin
        alu_a   = {{(AluW-CntW-1){1'b0}}, rem_q, p_q[WideW-1]};
        alu_b   = {{(AluW-CntW){1'b0}}, cnt_q};
        alu_sub = 1'b1;
      end
      StDiff: begin
        // q carries the sign of sum_x*sum_y
        alu_a   = {{(AluW-SxyW){sxy_q[SxyW-1]}}, sxy_q};
        alu_b   = {{(AluW-SxyW){1'b0}}, p_q[SxyW-1:0]};
        alu_sub = !(sx_q[SumW-1] ^ sy_q[SumW-1]);
      end
      StAbsD: begin
        alu_b   = diff_q;
        alu_sub = diff_q[AluW-1];
      end
      StOut: begin
        alu_b   = {{(AluW-SxyW){1'b0}}, p_q[SxyW-1:0]};
        alu_sub = dneg_q;
      end
      default: ;
    endcase
  end

  assign alu_sum = alu_a + (alu_b ^ {AluW{alu_sub}}) + AluW'(alu_sub);
  assign qbit    = !alu_sum[AluW-1];

  always_comb begin
    case (state_q)
      StMul:   step_last = StepW'(MulSteps - 1);
      StDiv1:  step_last = StepW'(Div1Steps - 1);
      default: step_last = StepW'(Div2Steps - 1);
    endcase
  end
  assign step_end = (step_q == step_last);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (accept) state_d = StAccX;
      StAccX: state_d = StAccY;
      StAccY: state_d = StAccP;
      StAccP: begin
        if (!last_q) state_d = StIdle;
        else if (cnt_q == '0 && !take_q) state_d = StDone;
        else state_d = StAbsX;
      end
      StAbsX: state_d = StAbsY;
      StAbsY: state_d = StMul;
      StMul:  if (step_end) state_d = StDiv1;
      StDiv1: if (step_end) state_d = StQSat;
      StQSat: state_d = StDiff;
      StDiff: state_d = StAbsD;
      StAbsD: state_d = StDiv2;
      StDiv2: if (step_end) state_d = StOut;
      StOut:  state_d = StDone;
      StDone: if (hand_over) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // control and set state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      cnt_q       <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      sxy_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StMul || state_q == StDiv1 || state_q == StDiv2) begin
        step_q <= step_end ? '0 : step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
      if (accept && !pair_missing_i && cnt_q == CntFull) ovf_q <= 1'b1;
      if (take_q) begin
        case (state_q)
          StAccX: sx_q <= alu_sum[SumW-1:0];
          StAccY: sy_q <= alu_sum[SumW-1:0];
          StAccP: begin
            sxy_q <= alu_sum[SxyW-1:0];
            cnt_q <= cnt_q + 1'b1;
          end
          default: ;
        endcase
      end
      if (state_q == StDone && hand_over) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (state_q == StDone && hand_over) begin
        cnt_q       <= '0;
        sx_q        <= '0;
        sy_q        <= '0;
        sxy_q       <= '0;
        ovf_q       <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= x_value_i;
      y_q    <= y_value_i;
      last_q <= last_of_set_i;
      take_q <= !pair_missing_i && (cnt_q != CntFull);
    end
    case (state_q)
      StAccX: prod_q <= ProdW'(x_q) * ProdW'(y_q);
      StAccP: begin
        null_q <= 1'b1;
        res_q  <= '0;
      end
      StAbsX: begin
        mag_a_q <= alu_sum[SumW-1:0];
        null_q  <= 1'b0;
      end
      StAbsY: begin
        p_q   <= {{(WideW-SumW){1'b0}}, alu_sum[SumW-1:0]};
        rem_q <= '0;
      end
      StMul: p_q <= {alu_sum[SumW:0], p_q[SumW-1:1]};
      StDiv1, StDiv2: begin
        rem_q <= qbit ? alu_sum[CntW-1:0] : {rem_q[CntW-2:0], p_q[WideW-1]};
        p_q   <= {p_q[WideW-2:0], qbit};
      end
      StQSat: begin
        if (p_q > QLimit) p_q <= {{(WideW-SxyW){1'b0}}, QSatVal};
        else p_q <= {{(WideW-SxyW){1'b0}}, p_q[SxyW-1:0]};
      end
      StDiff: diff_q <= alu_sum;
      StAbsD: begin
        dneg_q <= diff_q[AluW-1];
        p_q    <= {alu_sum[SxyW-1:0], {(WideW-SxyW){1'b0}}};
        rem_q  <= '0;
      end
      StOut: begin
        if (!dneg_q) begin
          res_q <= (p_q[SxyW-1:0] > PosLimit) ? CovMax : alu_sum[CovW-1:0];
        end else begin
          res_q <= (p_q[SxyW-1:0] > NegLimit) ? CovMin : alu_sum[CovW-1:0];
        end
      end
      StDone: begin
        if (hand_over) begin
          cov_q   <= res_q;
          rnull_q <= null_q;
          rovf_q  <= ovf_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign cov_result_o  = cov_q;
  assign result_null_o = rnull_q;
  assign overflow_o    = rovf_q;

endmodule
`default_nettype wire

// ----- hw/rtl/cova_checker.sv -----
// Port-level checks for the covariance accumulator, bound to the top level.
`default_nettype none
module cova_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_o,
  input  logic signed [cova_pkg::SampleW-1:0] x_value_i,
  input  logic signed [cova_pkg::SampleW-1:0] y_value_i,
  input  logic                                pair_missing_i,
  input  logic                                last_of_set_i,
  input  logic                                out_valid_o,
  input  logic                                out_ready_i,
  input  logic signed [cova_pkg::CovW-1:0]    cov_result_o,
  input  logic                                result_null_o,
  input  logic                                overflow_o
);
  import cova_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cov_result_o)
      && $stable(result_null_o) && $stable(overflow_o))
    else $error("stalled result changed");

  // an empty set reports zero
  a_null_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_null_o |-> cov_result_o == '0)
    else $error("null result with nonzero covariance");

  // the accumulation sequence keeps the input closed through the sum_x, sum_y and sum_xy states
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o)
    else $error("input reopened during accumulation");

endmodule

bind covariance_accumulator cova_checker u_cova_checker (.*);
`default_nettype wire

// ----- test/covariance_accumulator_tb.sv -----
// Self-checking testbench for the covariance accumulator: predicted results against the block.
`default_nettype none
module covariance_accumulator_tb;

  localparam int unsigned SampleW = cova_pkg::SampleW;
  localparam int unsigned CovW    = cova_pkg::CovW;

  localparam logic signed [SampleW-1:0] SampleMax = 24'sh7FFFFF;
  localparam logic signed [SampleW-1:0] SampleMin = 24'sh800000;

  // Drain time after the last expected result, with margin for a last item of a full set.
  localparam int DrainCycles = 400;
  // Long receiver hold-off, long enough that the output register and the
  // set behind it are both stuck and the input stalls.
  localparam int HoldCycles  = 600;
  // Cycles without any accepted transaction before the run is declared hung.
  localparam int StallLimit  = 4000;

  // Expected covariance result of one set
  typedef struct packed {
    logic signed [CovW-1:0] cov;
    logic                   empty;
    logic                   dropped;
  } cov_result_t;

  logic                      clk_i          = 1'b0;
  logic                      rst_ni         = 1'b0;
  logic                      in_valid       = 1'b0;
  logic                      in_ready;
  logic signed [SampleW-1:0] x_value        = '0;
  logic signed [SampleW-1:0] y_value        = '0;
  logic                      pair_missing   = 1'b0;
  logic                      last_of_set    = 1'b0;
  logic                      out_valid;
  logic                      out_ready      = 1'b0;
  logic signed [CovW-1:0]    cov_result;
  logic                      result_null;
  logic                      overflow;

  // Shared between the stimulus, the receiver, the monitor and the watchdog
  bit          idle_en        = 1'b1;
  bit          ready_hold_req = 1'b0;
  int          mismatch_count = 0;
  int          stall_cycles   = 0;
  cov_result_t cov_expected_q[$];

  // Predictor state: running sums of the set under way
  int unsigned acc_count = 0;
  longint      acc_sx    = 0;
  longint      acc_sy    = 0;
  longint      acc_sxy   = 0;
  bit          acc_ovf   = 1'b0;

  always #1 clk_i = ~clk_i;

  covariance_accumulator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .x_value_i      (x_value),
    .y_value_i      (y_value),
    .pair_missing_i (pair_missing),
    .last_of_set_i  (last_of_set),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .cov_result_o   (cov_result),
    .result_null_o  (result_null),
    .overflow_o     (overflow)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // (Sxy - Sx*Sy/n)/n, exact at 128 bits. Both divisions act on magnitudes,
  // so they truncate towards zero. The inner quotient saturates like the
  // hardware's, and the result clips to the 48-bit signed range.
  function automatic logic signed [CovW-1:0] population_cov();
    logic signed [127:0] sx_w, sy_w, sxy_w, q_w, diff_w;
    logic        [127:0] ax, ay, n_w, quo, dm, rm, neg_rm;
    logic                q_neg, d_neg;
    logic signed [CovW-1:0] res;
    sx_w  = acc_sx;
    sy_w  = acc_sy;
    sxy_w = acc_sxy;
    n_w   = 128'(acc_count);
    ax    = (sx_w < 0) ? -sx_w : sx_w;
    ay    = (sy_w < 0) ? -sy_w : sy_w;
    ax    = ax & 128'hFF_FFFF_FFFF;
    ay    = ay & 128'hFF_FFFF_FFFF;
    quo   = (ax * ay) / n_w;
    if (quo > 128'h4000_0000_FFFF_FFFF) quo = 128'h4000_0000_0000_0000;
    q_neg  = (acc_sx < 0) != (acc_sy < 0);
    q_w    = q_neg ? -$signed(quo) : $signed(quo);
    diff_w = sxy_w - q_w;
    d_neg  = diff_w < 0;
    dm     = d_neg ? -diff_w : diff_w;
    rm     = dm / n_w;
    if (!d_neg) begin
      res = (rm > 128'h7FFF_FFFF_FFFF) ? cova_pkg::CovMax : rm[CovW-1:0];
    end else begin
      neg_rm = -rm;
      res = (rm > 128'h8000_0000_0000) ? cova_pkg::CovMin : neg_rm[CovW-1:0];
    end
    return res;
  endfunction

  // Fold one accepted transaction into the sums; a last item closes the set.
  task automatic predict_item(logic signed [SampleW-1:0] x, logic signed [SampleW-1:0] y,
                              logic miss, logic last);
    cov_result_t r;
    if (!miss) begin
      if (acc_count >= cova_pkg::MaxPairs) begin
        acc_ovf = 1'b1;
      end else begin
        acc_count++;
        acc_sx  += longint'(x);
        acc_sy  += longint'(y);
        acc_sxy += longint'(x) * longint'(y);
      end
    end
    if (last) begin
      if (acc_count == 0) begin
        r.cov   = '0;
        r.empty = 1'b1;
      end else begin
        r.cov   = population_cov();
        r.empty = 1'b0;
      end
      r.dropped = acc_ovf;
      cov_expected_q.push_back(r);
      acc_count = 0;
      acc_sx    = 0;
      acc_sy    = 0;
      acc_sxy   = 0;
      acc_ovf   = 1'b0;
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h, want %0h", what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sampled at the rising edge, so both channels are seen with their
  // pre-edge values. Input transactions feed the predictor; output
  // transactions are checked against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cov_result_t e;
    if (rst_ni) begin
      if (in_valid && in_ready) predict_item(x_value, y_value, pair_missing, last_of_set);
      if (out_valid && out_ready) begin
        if (cov_expected_q.size() == 0) begin
          report_mismatch("unexpected result, cov", 64'(cov_result), 64'd0);
        end else begin
          e = cov_expected_q.pop_front();
          if (cov_result !== e.cov)
            report_mismatch("cov_result", 64'(cov_result), 64'(e.cov));
          if (result_null !== e.empty)
            report_mismatch("result_null", 64'(result_null), 64'(e.empty));
          if (overflow !== e.dropped)
            report_mismatch("overflow", 64'(overflow), 64'(e.dropped));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  // Watchdog: the block has stopped moving transactions
  initial begin
    wait (rst_ni);
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready in random idle bursts, or one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (ready_hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        ready_hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offer one pair; returns once the transaction has been taken.
  task automatic send_pair(logic signed [SampleW-1:0] x, logic signed [SampleW-1:0] y,
                           logic miss, logic last);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    x_value      <= x;
    y_value      <= y;
    pair_missing <= miss;
    last_of_set  <= last;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // Samples leaning on the extremes, zero and small values of either sign
  function automatic logic signed [SampleW-1:0] pick_sample();
    logic signed [SampleW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = SampleMax;
      1: v = SampleMin;
      2: v = '0;
      3: begin
        v = SampleW'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = SampleW'($urandom());
    endcase
    return v;
  endfunction

  // One set of len items, the last one flagged; miss_pct percent are null.
  task automatic send_set(int len, int miss_pct);
    int i;
    for (i = 0; i < len; i++)
      send_pair(pick_sample(), pick_sample(), ($urandom_range(0, 99) < miss_pct), i == len - 1);
  endtask

  task automatic test_directed_cases();
    // single pair: covariance is zero
    send_pair(SampleMax, SampleMax, 1'b0, 1'b1);
    // extremes of both signs: widest products and sums
    send_pair(SampleMax, SampleMax, 1'b0, 1'b0);
    send_pair(SampleMin, SampleMin, 1'b0, 1'b1);
    send_pair(SampleMax, SampleMin, 1'b0, 1'b0);
    send_pair(SampleMin, SampleMax, 1'b0, 1'b1);
    send_pair(SampleMin, SampleMin, 1'b0, 1'b0);
    send_pair(SampleMin, SampleMin, 1'b0, 1'b0);
    send_pair('0, '0, 1'b0, 1'b1);
    // empty sets: a lone null last item, then nulls only
    send_pair(SampleMax, SampleMin, 1'b1, 1'b1);
    send_pair(24'sd5, -24'sd5, 1'b1, 1'b0);
    send_pair(SampleMin, SampleMin, 1'b1, 1'b0);
    send_pair(SampleMax, SampleMax, 1'b1, 1'b1);
    // nulls mixed in, closing on a null last item
    send_pair(24'sd123, -24'sd45, 1'b0, 1'b0);
    send_pair(SampleMax, '0, 1'b1, 1'b0);
    send_pair(-24'sd1, -24'sd1, 1'b0, 1'b0);
    send_pair(24'sd1, SampleMax, 1'b1, 1'b1);
    // alternating bit patterns
    send_pair(24'sh555555, 24'shAAAAAA, 1'b0, 1'b0);
    send_pair(24'shAAAAAA, 24'sh555555, 1'b0, 1'b0);
    send_pair(24'sh000FFF, 24'shFFF000, 1'b0, 1'b1);
    send_pair('0, '0, 1'b0, 1'b1);
  endtask

  task automatic test_random_sets();
    int sent;
    int len;
    sent = 0;
    while (sent < 300) begin
      len = $urandom_range(1, 12);
      // now and then a set with nothing in it
      if ($urandom_range(0, 11) == 0) send_set(len, 100);
      else send_set(len, 15);
      sent += len;
    end
  endtask

  // Receiver holds off while short sets keep coming, so the input stalls.
  task automatic test_output_stall();
    int s;
    ready_hold_req = 1'b1;
    for (s = 0; s < 8; s++) send_set(2, 0);
    while (ready_hold_req) @(posedge clk_i);
  endtask

  // Last stretch runs back to back on both sides.
  task automatic test_steady_stream();
    int sent;
    int len;
    idle_en = 1'b0;
    sent = 0;
    while (sent < 80) begin
      len = $urandom_range(1, 8);
      send_set(len, 10);
      sent += len;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_random_sets();
    test_output_stall();
    test_steady_stream();
    in_valid <= 1'b0;
    while (cov_expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && cov_expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- covariance_accumulator.f -----
hw/rtl/cova_pkg.sv
hw/rtl/covariance_accumulator.sv
hw/rtl/cova_checker.sv
test/covariance_accumulator_tb.sv
